// ----- sv/i2c_bit_level_master_macros.svh -----
// assertion helpers for the bus sequencer
`ifndef I2C_BIT_LEVEL_MASTER_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_MACROS_SVH

// same-cycle implication, quiet during reset
`define I2CBM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define I2CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication checked through reset too
`define I2CBM_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/i2cbm_pkg.sv -----
package i2cbm_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd1000;
    localparam logic [3:0]  DATA_BITS         = 4'd8;

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       ready_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       done_res;
    } res_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       sda_in;
    } cmd_item_t;

    typedef struct packed {
        logic valid;
        logic take;
    } q_hs_t;

    function automatic logic [1:0] phases_in_step(input cmd_t cmd, input logic [3:0] bit_idx);
        logic [1:0] n;
        n = 2'd1;
        unique case (cmd)
            CMD_START: n = 2'd3;
            CMD_STOP:  n = 2'd2;
            CMD_WRITE: n = (bit_idx < DATA_BITS) ? 2'd3 : 2'd2;
            CMD_READ:  n = (bit_idx < DATA_BITS) ? 2'd2 :
                           ((bit_idx == DATA_BITS) ? 2'd3 : 2'd1);
            default:   n = 2'd1;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] steps_in_command(input cmd_t cmd);
        logic [3:0] n;
        n = 4'd1;
        unique case (cmd)
            CMD_WRITE: n = 4'd9;
            CMD_READ:  n = 4'd10;
            default:   n = 4'd1;
        endcase
        return n;
    endfunction

    // write bit: data with scl high, scl low, then sda low
    function automatic logic [1:0] write_bit_lines(input logic [1:0] phase, input logic v);
        logic [1:0] l;
        if (phase == 2'd0)
        begin
            l = {1'b1, v};
        end
        else if (phase == 2'd1)
        begin
            l = {1'b0, v};
        end
        else
        begin
            l = 2'b00;
        end
        return l;
    endfunction

    // returns {scl, sda}
    function automatic logic [1:0] line_levels(input cmd_t cmd, input logic [1:0] phase,
                                               input logic [3:0] bit_idx, input logic msb,
                                               input logic ack_latch, input logic [1:0] cur);
        logic [1:0] l;
        l = cur;
        unique case (cmd)
            CMD_START: l = {(phase < 2'd2), (phase == 2'd0)};
            CMD_STOP:  l = {1'b1, (phase != 2'd0) ? 1'b1 : cur[0]};
            CMD_WRITE:
            begin
                if (bit_idx < DATA_BITS)
                begin
                    l = write_bit_lines(phase, msb);
                end
                else
                begin
                    l = {(phase == 2'd0), 1'b1};
                end
            end
            CMD_READ:
            begin
                if (bit_idx < DATA_BITS)
                begin
                    l = {(phase == 2'd0), 1'b1};
                end
                else if (bit_idx == DATA_BITS)
                begin
                    l = write_bit_lines(phase, !ack_latch);
                end
            end
            default:   l = cur;
        endcase
        return l;
    endfunction

endpackage

// ----- sv/i2cbm_front.sv -----
module i2cbm_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  i2cbm_pkg::in_item_t   item,
    output i2cbm_pkg::cmd_item_t  mid_item,
    input  logic                  mid_take,
    output logic                  mid_valid
);
    import i2cbm_pkg::*;

    cmd_item_t           q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    cmd_item_t           decoded;
    logic                do_push;
    logic                do_pop;

    // unknown op codes act as no command
    always_comb
    begin
        decoded.tx_byte     = item.tx_byte;
        decoded.ack_to_send = item.ack_to_send;
        decoded.sda_in      = item.sda_in;
        unique case (item.op)
            CMD_START: decoded.cmd = CMD_START;
            CMD_STOP:  decoded.cmd = CMD_STOP;
            CMD_WRITE: decoded.cmd = CMD_WRITE;
            CMD_READ:  decoded.cmd = CMD_READ;
            default:   decoded.cmd = CMD_IDLE;
        endcase
    end

    assign full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign mid_valid = (cnt_reg != '0);
    assign mid_item  = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = mid_take && mid_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

// ----- sv/i2cbm_seq.sv -----
module i2cbm_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data,
    input  i2cbm_pkg::cmd_item_t  mid_item,
    input  i2cbm_pkg::q_hs_t      mid_hs_in,
    output i2cbm_pkg::q_hs_t      out_hs,
    input  logic                  out_full,
    output i2cbm_pkg::res_t       res_item
);
    import i2cbm_pkg::*;

    cmd_t        cmd_reg, cmd_next;
    logic [15:0] phase_ticks_reg;
    logic [15:0] tick_reg, tick_next;
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [1:0]  lines_reg, lines_next;
    logic        ack_flag_reg, ack_flag_next;
    logic [7:0]  rx_reg, rx_next;
    logic        ack_latch_reg, ack_latch_next;

    logic        step;
    logic [15:0] tick_inc;
    logic [15:0] limit;
    logic        phase_end;
    logic        finish;
    logic        done;
    logic [1:0]  ph_inc;
    logic [7:0]  shift_mid;
    cmd_t        run_cmd;

    assign cfg_ready    = 1'b1;
    assign step         = mid_hs_in.valid && !out_full;
    assign out_hs.valid = step;
    assign out_hs.take  = step;

    assign tick_inc  = tick_reg + 16'd1;
    assign limit     = (phase_ticks_reg == '0) ? 16'd1 : phase_ticks_reg;
    assign phase_end = tick_inc >= limit;

    // next state
    always_comb
    begin
        cmd_next = cmd_reg;
        unique case (cmd_reg)
            CMD_IDLE: cmd_next = mid_item.cmd;
            CMD_START, CMD_STOP, CMD_WRITE, CMD_READ:
            begin
                if (finish)
                begin
                    cmd_next = CMD_IDLE;
                end
            end
            default:  cmd_next = CMD_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        tick_next      = tick_reg;
        phase_next     = phase_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        lines_next     = lines_reg;
        ack_flag_next  = ack_flag_reg;
        rx_next        = rx_reg;
        ack_latch_next = ack_latch_reg;
        finish         = 1'b0;
        done           = 1'b0;
        ph_inc         = phase_reg + 2'd1;
        shift_mid      = shift_reg;
        run_cmd        = cmd_reg;

        if (cmd_reg == CMD_IDLE)
        begin
            if (mid_item.cmd != CMD_IDLE)
            begin
                run_cmd    = mid_item.cmd;
                tick_next  = '0;
                phase_next = '0;
                bit_next   = '0;
                if (mid_item.cmd == CMD_WRITE)
                begin
                    shift_next = mid_item.tx_byte;
                end
                if (mid_item.cmd == CMD_READ)
                begin
                    shift_next     = '0;
                    ack_latch_next = mid_item.ack_to_send;
                end
                lines_next = line_levels(run_cmd, 2'd0, 4'd0, shift_next[7],
                                         ack_latch_next, lines_reg);
            end
        end
        else
        begin
            tick_next = tick_inc;
            if (phase_end)
            begin
                tick_next = '0;
                if (phase_reg == 2'd0)
                begin
                    if (cmd_reg == CMD_WRITE && bit_reg == DATA_BITS)
                    begin
                        ack_flag_next = !mid_item.sda_in;
                    end
                    else if (cmd_reg == CMD_READ && bit_reg < DATA_BITS)
                    begin
                        shift_mid = {shift_reg[6:0], mid_item.sda_in};
                    end
                end
                shift_next = shift_mid;
                phase_next = ph_inc;
                if (ph_inc >= phases_in_step(cmd_reg, bit_reg))
                begin
                    phase_next = '0;
                    if (cmd_reg == CMD_WRITE && bit_reg < DATA_BITS)
                    begin
                        shift_next = {shift_mid[6:0], 1'b0};
                    end
                    bit_next = bit_reg + 4'd1;
                end
                if (bit_next >= steps_in_command(cmd_reg))
                begin
                    finish = 1'b1;
                    done   = 1'b1;
                    if (cmd_reg == CMD_READ)
                    begin
                        rx_next = shift_next;
                    end
                    bit_next   = '0;
                    phase_next = '0;
                end
                else
                begin
                    lines_next = line_levels(cmd_reg, phase_next, bit_next, shift_next[7],
                                             ack_latch_reg, lines_reg);
                end
            end
        end
    end

    always_comb
    begin
        res_item.scl_release = lines_reg[1];
        res_item.sda_release = lines_reg[0];
        res_item.ready_res   = (cmd_reg == CMD_IDLE);
        res_item.rx_byte     = rx_next;
        res_item.ack_seen    = ack_flag_next;
        res_item.done_res    = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            phase_ticks_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= CMD_IDLE;
            tick_reg      <= '0;
            phase_reg     <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            lines_reg     <= 2'b11;
            ack_flag_reg  <= 1'b0;
            rx_reg        <= '0;
            ack_latch_reg <= 1'b0;
        end
        else if (step)
        begin
            cmd_reg       <= cmd_next;
            tick_reg      <= tick_next;
            phase_reg     <= phase_next;
            bit_reg       <= bit_next;
            shift_reg     <= shift_next;
            lines_reg     <= lines_next;
            ack_flag_reg  <= ack_flag_next;
            rx_reg        <= rx_next;
            ack_latch_reg <= ack_latch_next;
        end
    end

endmodule

// ----- sv/i2cbm_outq.sv -----
module i2cbm_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  i2cbm_pkg::q_hs_t  in_hs,
    output logic              in_full,
    input  i2cbm_pkg::res_t   in_item,
    output logic              empty,
    input  logic              pop,
    output i2cbm_pkg::res_t   res
);
    import i2cbm_pkg::*;

    res_t                q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push;
    logic                do_pop;

    assign in_full = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign res     = q_reg[rd_ptr_reg];
    assign do_push = in_hs.valid && !in_full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- sv/i2c_bit_level_master.sv -----
// path: a pushed word is written to the input queue, and its result to the result queue
// throughput: one word per cycle while the result queue has room, set by the phase counter step
// a full result queue stalls the sequencer; input queue holds two words
// reset (async, active low): queues empty, sequencer idle, lines released
// reset: phase_ticks returns to 1000
module i2c_bit_level_master (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  i2cbm_pkg::in_item_t  cmd_word,
    output logic                 empty,
    input  logic                 pop,
    output i2cbm_pkg::res_t      res_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data
);
    import i2cbm_pkg::*;

    cmd_item_t mid_item;
    q_hs_t     mid_hs;
    q_hs_t     out_hs;
    logic      out_full;
    res_t      seq_res;

    i2cbm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (cmd_word),
        .mid_item  (mid_item),
        .mid_take  (out_hs.take),
        .mid_valid (mid_hs.valid)
    );

    assign mid_hs.take = out_hs.take;

    i2cbm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .mid_item  (mid_item),
        .mid_hs_in (mid_hs),
        .out_hs    (out_hs),
        .out_full  (out_full),
        .res_item  (seq_res)
    );

    i2cbm_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_hs   (out_hs),
        .in_full (out_full),
        .in_item (seq_res),
        .empty   (empty),
        .pop     (pop),
        .res     (res_word)
    );

endmodule

// ----- sv/i2cbm_checker.sv -----
`include "i2c_bit_level_master_macros.svh"

module i2cbm_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 push,
    input logic                 full,
    input i2cbm_pkg::in_item_t  cmd_word,
    input logic                 empty,
    input logic                 pop,
    input i2cbm_pkg::res_t      res_word,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [15:0]          cfg_data
);
    import i2cbm_pkg::*;

    res_t res_seen;
    assign res_seen = res_word;

    // waiting result holds until taken
    `I2CBM_ASSERT_NEXT(a_res_hold, clk, rst_n, !empty && !pop,
        !empty && $stable(res_seen), "result changed while stalled")

    // a command cannot complete on a tick that began idle
    `I2CBM_ASSERT_IMPL(a_done_busy, clk, rst_n, !empty && res_seen.done_res,
        !res_seen.ready_res, "done reported while idle")

    // queues come out of reset empty
    `I2CBM_ASSERT_ALWAYS(a_reset_empty, clk, $rose(rst_n), empty && !full,
        "queues not empty after reset")

    // config writes always taken
    `I2CBM_ASSERT_IMPL(a_cfg_ready, clk, rst_n,
        cfg_valid && !push && cmd_word.op == CMD_IDLE && cfg_data != 16'd0,
        cfg_ready, "config write refused")

endmodule

bind i2c_bit_level_master i2cbm_checker u_checker (.*);
